[design/dual_stack_shared_memory_macros.svh]
// assertion macros shared by the dual stack rtl
// expects signals clk and rst_n in the scope of each use
`ifndef DUAL_STACK_SHARED_MEMORY_MACROS_SVH
`define DUAL_STACK_SHARED_MEMORY_MACROS_SVH

// same-cycle implication, disabled in reset
`define DSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dss assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define DSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dss assertion failed: next-cycle implication");

`endif

[design/dss_pkg.sv]
// types and constants for the dual stack shared memory block
// no dependencies
`default_nettype none

package dss_pkg;

  // register file
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 9;
  localparam int DEPTH_DEF   = 256;
  localparam int CAP_RESET   = 256;
  localparam int APB_W       = 32;
  localparam int PADDR_W     = 3;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;

  // command queue between front and back
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH1 = 2'd0,
    CMD_PUSH2 = 2'd1,
    CMD_POP1  = 2'd2,
    CMD_POP2  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // register index of the capacity register
  localparam logic REG_CAPACITY = 1'b0;

  // what the back end has to do for one command
  typedef struct packed {
    logic    wr;
    logic    rd;
    status_t status;
  } q_ctl_t;

endpackage

`default_nettype wire

[design/dss_ram.sv]
// generic single-write single-read ram with registered read data
// no dependencies
`default_nettype none

module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/dss_front.sv]
// front end: accepts commands, checks the fill counts, works out addresses
// depends on dss_pkg and dual_stack_shared_memory_macros.svh
`default_nettype none

module dss_front #(
  parameter int DEPTH = dss_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // command beats
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [dss_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic [dss_pkg::DATA_W-1:0]  in_value,
  // capacity register
  input  wire logic                        cap_we,
  input  wire logic [dss_pkg::CAP_W-1:0]   cap_wdata,
  output      logic [dss_pkg::CAP_W-1:0]   cap_rdata,
  // to the queue
  output      logic                        q_push,
  input  wire logic                        q_full,
  output      dss_pkg::q_ctl_t             q_ctl,
  output      logic [$clog2(DEPTH)-1:0]    q_addr,
  output      logic [dss_pkg::DATA_W-1:0]  q_data
);
  import dss_pkg::*;
  `include "dual_stack_shared_memory_macros.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] capacity_r, capacity_nxt;
  logic [CNT_W-1:0] count_low_r, count_low_nxt;
  logic [CNT_W-1:0] count_high_r, count_high_nxt;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] depth_ext;
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W:0]   fill_sum;
  logic             no_room;
  logic [CNT_W-1:0] pos;
  logic             accept;
  cmd_t             cmd;

  assign cmd      = cmd_t'(in_cmd);
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;
  assign q_data   = in_value;
  assign cap_rdata = capacity_r;

  // capacity saturates at the memory depth
  assign cap_ext   = CMP_W'(capacity_r);
  assign depth_ext = CMP_W'(DEPTH);
  assign cap_eff   = CNT_W'((cap_ext > depth_ext) ? depth_ext : cap_ext);

  assign fill_sum = {1'b0, count_low_r} + {1'b0, count_high_r};
  assign no_room  = fill_sum >= {1'b0, cap_eff};

  // classify the command
  always_comb begin
    q_ctl          = '{wr: 1'b0, rd: 1'b0, status: ST_OK};
    pos            = '0;
    count_low_nxt  = count_low_r;
    count_high_nxt = count_high_r;
    unique case (cmd)
      CMD_PUSH1: begin
        pos = count_low_r;
        if (no_room) begin
          q_ctl.status = ST_OVERFLOW;
        end else begin
          q_ctl.wr = 1'b1;
          if (accept) count_low_nxt = count_low_r + 1'b1;
        end
      end
      CMD_PUSH2: begin
        pos = cap_eff - 1'b1 - count_high_r;
        if (no_room) begin
          q_ctl.status = ST_OVERFLOW;
        end else begin
          q_ctl.wr = 1'b1;
          if (accept) count_high_nxt = count_high_r + 1'b1;
        end
      end
      CMD_POP1: begin
        pos = count_low_r - 1'b1;
        if (count_low_r == '0) begin
          q_ctl.status = ST_UNDERFLOW;
        end else begin
          q_ctl.rd = 1'b1;
          if (accept) count_low_nxt = count_low_r - 1'b1;
        end
      end
      CMD_POP2: begin
        pos = cap_eff - count_high_r;
        if (count_high_r == '0) begin
          q_ctl.status = ST_UNDERFLOW;
        end else begin
          q_ctl.rd = 1'b1;
          if (accept) count_high_nxt = count_high_r - 1'b1;
        end
      end
      default: begin
        q_ctl.status = ST_UNDERFLOW;
      end
    endcase
  end

  assign q_addr = pos[AW-1:0];

  // capacity only changes while both stacks are empty
  always_comb begin
    capacity_nxt = capacity_r;
    if (cap_we && count_low_r == '0 && count_high_r == '0) begin
      capacity_nxt = cap_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r   <= CAP_W'(CAP_RESET);
      count_low_r  <= '0;
      count_high_r <= '0;
    end else begin
      capacity_r   <= capacity_nxt;
      count_low_r  <= count_low_nxt;
      count_high_r <= count_high_nxt;
    end
  end

  `DSS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_sum <= (CNT_W+1)'(DEPTH))
  `DSS_ASSERT_NEXT(a_refused_holds, accept && q_ctl.status != ST_OK,
                   $stable(count_low_r) && $stable(count_high_r))
  `DSS_ASSERT_IMPL(a_one_access, accept, !(q_ctl.wr && q_ctl.rd))

endmodule

`default_nettype wire

[design/dss_queue.sv]
// two-entry command queue between the front and back ends
// depends on dss_pkg
`default_nettype none

module dss_queue #(
  parameter int DEPTH = dss_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output      logic                        full,
  input  wire dss_pkg::q_ctl_t             wr_ctl,
  input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  wire logic [dss_pkg::DATA_W-1:0]  wr_data,
  input  wire logic                        pop,
  output      logic                        valid,
  output      dss_pkg::q_ctl_t             rd_ctl,
  output      logic [$clog2(DEPTH)-1:0]    rd_addr,
  output      logic [dss_pkg::DATA_W-1:0]  rd_data
);
  import dss_pkg::*;

  localparam int AW = $clog2(DEPTH);

  q_ctl_t             ctl_r  [QDEPTH];
  logic [AW-1:0]      addr_r [QDEPTH];
  logic [DATA_W-1:0]  data_r [QDEPTH];
  logic [QPTR_W-1:0]  wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]  rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = cnt_r == QCNT_W'(QDEPTH);
  assign valid   = cnt_r != '0;
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  assign rd_ctl  = ctl_r[rptr_r];
  assign rd_addr = addr_r[rptr_r];
  assign rd_data = data_r[rptr_r];

  // pointer and fill update
  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ctl_r[wptr_r]  <= wr_ctl;
      addr_r[wptr_r] <= wr_addr;
      data_r[wptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[design/dss_back.sv]
// back end: drives the shared ram and holds the result beat
// depends on dss_pkg, dss_ram and dual_stack_shared_memory_macros.svh
`default_nettype none

module dss_back #(
  parameter int DEPTH = dss_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // from the queue
  input  wire logic                        q_valid,
  output      logic                        q_pop,
  input  wire dss_pkg::q_ctl_t             q_ctl,
  input  wire logic [$clog2(DEPTH)-1:0]    q_addr,
  input  wire logic [dss_pkg::DATA_W-1:0]  q_data,
  // result beats
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [dss_pkg::DATA_W-1:0]  out_data,
  output      logic [dss_pkg::STATUS_W-1:0] out_status
);
  import dss_pkg::*;
  `include "dual_stack_shared_memory_macros.svh"

  localparam int AW = $clog2(DEPTH);

  logic              s1_v_r, s1_v_nxt;
  q_ctl_t            s1_ctl_r;
  logic              out_v_r, out_v_nxt;
  logic [DATA_W-1:0] out_data_r;
  status_t           out_status_r;
  logic [DATA_W-1:0] rdata;
  logic              out_free;
  logic              s1_move;
  logic              take;

  // flow control through the ram stage and the output register
  assign out_free = !out_v_r || out_ready;
  assign s1_move  = s1_v_r && out_free;
  assign take     = q_valid && (!s1_v_r || s1_move);
  assign q_pop    = take;

  dss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (take && q_ctl.wr),
    .waddr (q_addr),
    .wdata (q_data),
    .re    (take && q_ctl.rd),
    .raddr (q_addr[AW-1:0]),
    .rdata (rdata)
  );

  // valid bits of the two stages
  always_comb begin
    s1_v_nxt  = take ? 1'b1 : (s1_move ? 1'b0 : s1_v_r);
    out_v_nxt = s1_move ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload of the ram stage and the result register
  always_ff @(posedge clk) begin
    if (take) begin
      s1_ctl_r <= q_ctl;
    end
    if (s1_move) begin
      out_data_r   <= s1_ctl_r.rd ? rdata : '0;
      out_status_r <= s1_ctl_r.status;
    end
  end

  assign out_valid  = out_v_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;

  `DSS_ASSERT_IMPL(a_fail_has_no_data, out_v_r && out_status_r != ST_OK, out_data_r == '0)
  `DSS_ASSERT_NEXT(a_stage_advances, s1_move && !take, !s1_v_r)

endmodule

`default_nettype wire

[design/dual_stack_shared_memory.sv]
// Two stacks sharing one memory: stack one grows up from entry 0, stack two
// grows down from entry capacity-1.
// Input channel: in_tuser carries the command (push one, push two, pop one,
// pop two), in_tdata the value for a push. Every accepted beat gives exactly
// one result beat, in order: out_tdata is the popped value (zero on pushes
// and failed pops), out_tuser the status (ok, overflow, underflow).
// A refused command leaves both stacks as they were.
// A result passes through the queue, the ram stage and the output register.
// Throughput: one command per cycle while the receiver keeps up, set by the
// single ram access each command makes in the back end.
// A two-entry queue separates command checking from the ram; the front keeps
// accepting while the queue has room, so a stalled receiver fills the output
// register, the ram stage and the queue, and then in_tready drops.
// Reset clears both fill counts and sets the capacity to 256; memory
// contents are not cleared and need no clearing pass.
// Capacity (register 0 on the apb port) is taken only while both stacks are
// empty and saturates at the memory depth.
// depends on dss_pkg, dss_front, dss_queue and dss_back
`default_nettype none

module dual_stack_shared_memory #(
  parameter int DEPTH = dss_pkg::DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input stream
  input  wire logic                         in_tvalid,
  output      logic                         in_tready,
  input  wire logic signed [31:0]           in_tdata,   // [31:0] push_value
  input  wire logic [1:0]                   in_tuser,   // [1:0] cmd
  // result stream
  output      logic                         out_tvalid,
  input  wire logic                         out_tready,
  output      logic signed [31:0]           out_tdata,  // [31:0] pop_value
  output      logic [1:0]                   out_tuser,  // [1:0] status
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dss_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [dss_pkg::APB_W-1:0]    pwdata,
  output      logic [dss_pkg::APB_W-1:0]    prdata,
  output      logic                         pready
);
  import dss_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic              cap_we;
  logic [CAP_W-1:0]  cap_rdata;
  logic              reg_sel;
  logic              q_push, q_full, q_pop, q_valid;
  q_ctl_t            f_ctl, b_ctl;
  logic [AW-1:0]     f_addr, b_addr;
  logic [DATA_W-1:0] f_data, b_data;
  logic [DATA_W-1:0] res_data;
  logic [STATUS_W-1:0] res_status;

  // apb decode, single register
  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == REG_CAPACITY;
  assign cap_we  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? APB_W'(cap_rdata) : '0;

  dss_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_value  (in_tdata),
    .cap_we    (cap_we),
    .cap_wdata (pwdata[CAP_W-1:0]),
    .cap_rdata (cap_rdata),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_ctl     (f_ctl),
    .q_addr    (f_addr),
    .q_data    (f_data)
  );

  dss_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_ctl  (f_ctl),
    .wr_addr (f_addr),
    .wr_data (f_data),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_ctl  (b_ctl),
    .rd_addr (b_addr),
    .rd_data (b_data)
  );

  dss_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_ctl      (b_ctl),
    .q_addr     (b_addr),
    .q_data     (b_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (res_data),
    .out_status (res_status)
  );

  assign out_tdata = res_data;
  assign out_tuser = res_status;

endmodule

`default_nettype wire

[dv/dual_stack_shared_memory_tb.sv]
// self-checking testbench for the dual stack shared memory block
// depends on dss_pkg and dual_stack_shared_memory; drives both streams and the apb port
`default_nettype none

module dual_stack_shared_memory_tb;
  import dss_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RST_CYCLES    = 5;
  localparam int PHASE_ITEMS   = 195;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 4;     // extra wait after the last predicted result
  localparam int DRAIN_LIMIT   = 20000;
  localparam int MAX_REPORTS   = 10;
  localparam int N_ROWS        = 32;
  localparam int MEM_AW        = $clog2(DEPTH_DEF);
  localparam logic [PADDR_W-1:0] CAP_ADDR   = PADDR_W'(4 * REG_CAPACITY);
  localparam logic [PADDR_W-1:0] SPARE_ADDR = CAP_ADDR + PADDR_W'(4);

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    cmd_t                 cmd;
    logic [31:0]          data;
    logic [PADDR_W-1:0]   addr;
    bit                   fixed;
    logic [31:0]          exp_value;
    status_t              exp_status;
  } stim_row_t;

  typedef struct {
    logic [DATA_W-1:0] pop_value;
    status_t           status;
  } stack_result_t;

  // clock, reset and block inputs, all known from time zero
  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic signed [31:0]       in_tdata   = '0;
  logic [1:0]               in_tuser   = '0;
  logic                     out_tready = 1'b0;
  logic                     psel       = 1'b0;
  logic                     penable    = 1'b0;
  logic                     pwrite     = 1'b0;
  logic [PADDR_W-1:0]       paddr      = '0;
  logic [APB_W-1:0]         pwdata     = '0;
  logic                     in_tready;
  logic                     out_tvalid;
  logic signed [31:0]       out_tdata;
  logic [1:0]               out_tuser;
  logic [APB_W-1:0]         prdata;
  logic                     pready;

  // mirror of the block state
  logic [DATA_W-1:0]        mirror_mem [DEPTH_DEF];
  logic [CAP_W-1:0]         mirror_cnt_up   = '0;
  logic [CAP_W-1:0]         mirror_cnt_down = '0;
  logic [CAP_W-1:0]         mirror_cap      = CAP_W'(CAP_RESET);

  stack_result_t            pending_results [$];

  int  mismatch_cnt = 0;
  int  error_cnt    = 0;
  int  n_items      = 0;
  int  n_results    = 0;
  int  n_overflow   = 0;
  int  n_underflow  = 0;
  int  n_cfg        = 0;
  int  burst_left   = 0;
  bit  pressure_on  = 1'b0;
  bit  hold_req     = 1'b0;

  // directed rows: fixed expectations only after reset, at extremes and for error codes
  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_CFG,  CMD_PUSH1, 32'h0000_0001, SPARE_ADDR, 1'b0, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_POP1,  32'h0000_0000, CAP_ADDR,   1'b1, 32'h0, ST_UNDERFLOW},
    '{ROW_ITEM, CMD_POP2,  32'h0000_0000, CAP_ADDR,   1'b1, 32'h0, ST_UNDERFLOW},
    '{ROW_ITEM, CMD_PUSH1, 32'h7FFF_FFFF, CAP_ADDR,   1'b1, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_PUSH2, 32'h8000_0000, CAP_ADDR,   1'b1, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_PUSH1, 32'hFFFF_FFFF, CAP_ADDR,   1'b1, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_PUSH2, 32'h0000_0000, CAP_ADDR,   1'b1, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_PUSH1, 32'h0000_0001, CAP_ADDR,   1'b1, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_POP1,  32'h1111_1111, CAP_ADDR,   1'b0, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_POP2,  32'h2222_2222, CAP_ADDR,   1'b0, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_POP1,  32'h0000_0000, CAP_ADDR,   1'b0, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_POP2,  32'h0000_0000, CAP_ADDR,   1'b0, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_POP1,  32'h0000_0000, CAP_ADDR,   1'b0, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_POP1,  32'h0000_0000, CAP_ADDR,   1'b1, 32'h0, ST_UNDERFLOW},
    '{ROW_ITEM, CMD_POP2,  32'h0000_0000, CAP_ADDR,   1'b1, 32'h0, ST_UNDERFLOW},
    // single-entry memory
    '{ROW_CFG,  CMD_PUSH1, 32'h0000_0001, CAP_ADDR,   1'b0, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_PUSH2, 32'h1234_5678, CAP_ADDR,   1'b1, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_PUSH1, 32'hCAFE_F00D, CAP_ADDR,   1'b1, 32'h0, ST_OVERFLOW},
    '{ROW_ITEM, CMD_PUSH2, 32'h0BAD_0BAD, CAP_ADDR,   1'b1, 32'h0, ST_OVERFLOW},
    // write while stack two holds an entry is dropped
    '{ROW_CFG,  CMD_PUSH1, 32'h0000_0002, CAP_ADDR,   1'b0, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_PUSH1, 32'h5555_AAAA, CAP_ADDR,   1'b1, 32'h0, ST_OVERFLOW},
    '{ROW_ITEM, CMD_POP2,  32'h0000_0000, CAP_ADDR,   1'b0, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_POP2,  32'h0000_0000, CAP_ADDR,   1'b1, 32'h0, ST_UNDERFLOW},
    // no room at all
    '{ROW_CFG,  CMD_PUSH1, 32'h0000_0000, CAP_ADDR,   1'b0, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_PUSH1, 32'hFFFF_FFFF, CAP_ADDR,   1'b1, 32'h0, ST_OVERFLOW},
    '{ROW_ITEM, CMD_PUSH2, 32'h8000_0000, CAP_ADDR,   1'b1, 32'h0, ST_OVERFLOW},
    '{ROW_ITEM, CMD_POP1,  32'h0000_0000, CAP_ADDR,   1'b1, 32'h0, ST_UNDERFLOW},
    // capacity above the depth saturates
    '{ROW_CFG,  CMD_PUSH1, 32'h0000_01FF, CAP_ADDR,   1'b0, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_PUSH2, 32'hA5A5_A5A5, CAP_ADDR,   1'b1, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_PUSH1, 32'h5A5A_5A5A, CAP_ADDR,   1'b1, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_POP2,  32'h0000_0000, CAP_ADDR,   1'b0, 32'h0, ST_OK},
    '{ROW_ITEM, CMD_POP1,  32'h0000_0000, CAP_ADDR,   1'b0, 32'h0, ST_OK}
  };

  // capacity settings of the random phases, negative picks one at random
  int phase_caps [10] = '{256, 1, 2, 0, 511, 300, 3, 255, 17, -1};

  dual_stack_shared_memory #(
    .DEPTH (DEPTH_DEF)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [31:0] push_value
    .in_tuser   (in_tuser),     // [1:0] cmd
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [31:0] pop_value
    .out_tuser  (out_tuser),    // [1:0] status
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  // capacity in effect, saturated at the memory depth
  function automatic logic [CAP_W-1:0] cap_limit();
    return (mirror_cap > CAP_W'(DEPTH_DEF)) ? CAP_W'(DEPTH_DEF) : mirror_cap;
  endfunction

  // stack behaviour for one command, updates the mirror
  function automatic stack_result_t compute_stack_result(cmd_t c, logic [DATA_W-1:0] v);
    stack_result_t    r;
    logic [CAP_W-1:0] lim;
    logic [CAP_W:0]   fill;
    logic [CAP_W-1:0] pos;
    lim         = cap_limit();
    fill        = {1'b0, mirror_cnt_up} + {1'b0, mirror_cnt_down};
    r.pop_value = '0;
    r.status    = ST_OK;
    case (c)
      CMD_PUSH1: begin
        if (fill >= {1'b0, lim}) begin
          r.status = ST_OVERFLOW;
        end else begin
          mirror_mem[mirror_cnt_up[MEM_AW-1:0]] = v;
          mirror_cnt_up++;
        end
      end
      CMD_PUSH2: begin
        if (fill >= {1'b0, lim}) begin
          r.status = ST_OVERFLOW;
        end else begin
          pos = lim - 1'b1 - mirror_cnt_down;
          mirror_mem[pos[MEM_AW-1:0]] = v;
          mirror_cnt_down++;
        end
      end
      CMD_POP1: begin
        if (mirror_cnt_up == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          pos = mirror_cnt_up - 1'b1;
          r.pop_value = mirror_mem[pos[MEM_AW-1:0]];
          mirror_cnt_up--;
        end
      end
      default: begin
        if (mirror_cnt_down == 0 || mirror_cnt_down > lim) begin
          r.status = ST_UNDERFLOW;
        end else begin
          pos = lim - mirror_cnt_down;
          r.pop_value = mirror_mem[pos[MEM_AW-1:0]];
          mirror_cnt_down--;
        end
      end
    endcase
    return r;
  endfunction

  // offer one beat in bursts with random gaps, predict on acceptance
  task automatic send_item(input cmd_t c, input logic [31:0] v, input bit fixed,
                           input logic [31:0] fix_value, input status_t fix_status);
    int            gap;
    stack_result_t r;
    if (burst_left == 0) begin
      gap = pressure_on ? 0 : ($urandom_range(0, 9) < 3 ? 0 : $urandom_range(1, 6));
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    r = compute_stack_result(c, v);
    if (fixed) begin
      r.pop_value = fix_value;
      r.status    = fix_status;
    end
    if (r.status == ST_OVERFLOW) n_overflow++;
    if (r.status == ST_UNDERFLOW) n_underflow++;
    pending_results.push_back(r);
    n_items++;
  endtask

  // stop offering and let every outstanding result come out
  task automatic settle();
    if (in_tvalid) in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write, setup then access, only with the block idle
  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [APB_W-1:0] data);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[PADDR_W-1:2] == REG_CAPACITY && mirror_cnt_up == 0 && mirror_cnt_down == 0)
      mirror_cap = data[CAP_W-1:0];
    n_cfg++;
  endtask

  // empty both stacks so that a new capacity takes effect
  task automatic drain_stacks();
    int n_up;
    int n_down;
    n_up   = int'(mirror_cnt_up);
    n_down = int'(mirror_cnt_down);
    repeat (n_up) send_item(CMD_POP1, $urandom(), 1'b0, '0, ST_OK);
    repeat (n_down) send_item(CMD_POP2, $urandom(), 1'b0, '0, ST_OK);
  endtask

  // receiver: segments of own stall pattern, plus long hold-off on request
  initial begin : receiver
    int seg_mode;
    int seg_left;
    int hold_left;
    int rx_tick;
    seg_mode  = 0;
    seg_left  = 0;
    hold_left = 0;
    rx_tick   = 0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(8, 80);
        end
        seg_left--;
        case (seg_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= (rx_tick % 4 == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    stack_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result beat: value %h status %0d", out_tdata, out_tuser);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.pop_value || out_tuser !== want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("result %0d: expected value %h status %0d, got value %h status %0d",
                     n_results, want.pop_value, want.status, out_tdata, out_tuser);
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int          cap_val;
    int          lim;
    int          run_left;
    bit          push_trend;
    bit          is_push;
    bit          to_two;
    cmd_t        c;
    logic [31:0] v;
    int          wait_cnt;
    run_left   = 0;
    push_trend = 1'b0;

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        cfg_write(directed_rows[i].addr, directed_rows[i].data);
      end else begin
        send_item(directed_rows[i].cmd, directed_rows[i].data, directed_rows[i].fixed,
                  directed_rows[i].exp_value, directed_rows[i].exp_status);
      end
    end

    // random phases, one per capacity setting
    foreach (phase_caps[p]) begin
      drain_stacks();
      cap_val = (phase_caps[p] < 0) ? $urandom_range(1, DEPTH_DEF) : phase_caps[p];
      cfg_write(CAP_ADDR, ($urandom() & ~32'h1FF) | cap_val[31:0]);
      lim = int'(cap_limit());
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // receiver holds off while the sender keeps offering
        if (k == 20) begin
          hold_req    = 1'b1;
          pressure_on = 1'b1;
        end
        if (k == 20 + HOLD_CYCLES / 2) pressure_on = 1'b0;
        // fill and empty runs, with the odd opposite command as noise
        if (run_left == 0) begin
          push_trend = !push_trend;
          run_left   = $urandom_range(1, lim + 8);
        end
        run_left--;
        is_push = ($urandom_range(0, 9) < (push_trend ? 9 : 1));
        to_two  = 1'($urandom_range(0, 1));
        c = is_push ? (to_two ? CMD_PUSH2 : CMD_PUSH1) : (to_two ? CMD_POP2 : CMD_POP1);
        case ($urandom_range(0, 7))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          3:       v = 32'hFFFF_FFFF;
          default: v = $urandom();
        endcase
        send_item(c, v, 1'b0, '0, ST_OK);
      end
    end

    // wait for the last results, bounded
    if (in_tvalid) in_tvalid <= 1'b0;
    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      error_cnt++;
      $display("%0d predicted results never arrived", pending_results.size());
    end

    $display("sent %0d command beats across %0d register writes, %0d result beats checked",
             n_items, n_cfg, n_results);
    $display("predicted %0d overflow and %0d underflow responses, %0d mismatches",
             n_overflow, n_underflow, mismatch_cnt);
    if (mismatch_cnt == 0 && error_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
